[hdl/assert_macros.svh]
// Assertion macros used by the top module of the two-window search block.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold on every clock edge out of reset
`define BTDW_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BTDW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/btdw_pkg.sv]
// Shared constants and types for the two-window search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package btdw_pkg;

    localparam int LEN_W          = 11;     // window length register
    localparam int VALUE_W        = 30;     // input value
    localparam int START_W        = 17;     // reported 1-based starts
    localparam int MAX_WINDOW_DEF = 1024;
    localparam int MAX_ITEMS_DEF  = 65536;

    // per-beat control flags carried from the front stage to the tracker
    typedef struct packed {
        logic active;       // beat updates the stream (not past the item bound)
        logic last;         // beat closes the stream
        logic sub_en;       // oldest value leaves the sliding sum
        logic win_en;       // a window completes with this beat
        logic pair_en;      // an earlier disjoint window exists
        logic first_pair;   // very first pair: taken regardless of sum
        logic found_ok;     // stream fit the bound and holds two windows
    } s1_ctl_t;

    typedef struct packed {
        logic [START_W-1:0] first_start;
        logic [START_W-1:0] second_start;
        logic               found;
    } result_t;

endpackage

`default_nettype wire

[hdl/btdw_front.sv]
// Front stage: beat counter, delay-line addressing and the value delay memory.
// Depends on btdw_pkg.
`default_nettype none

module btdw_front
    import btdw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int IW = $clog2(MAX_ITEMS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,
    input  logic               accept,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    input  logic               s1_go,
    output logic               s1_valid,
    output s1_ctl_t            s1_ctl,
    output logic [VALUE_W-1:0] s1_value,
    output logic [IW-1:0]      s1_j,
    output logic [IW-1:0]      s1_jk,
    output logic [AW-1:0]      s1_sd_wr,
    output logic [VALUE_W-1:0] s1_vd_rd,
    output logic [AW-1:0]      sd_rd_addr
);

    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = ((CW > KW) ? CW : KW) + 1;

    logic [KW-1:0]      k_reg, k_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic               s1_valid_reg, s1_valid_next;
    s1_ctl_t            ctl_reg, ctl_c;
    logic [VALUE_W-1:0] value_reg;
    logic [IW-1:0]      j_reg, jk_reg;
    logic [AW-1:0]      sd_wr_reg, sd_wr_c, vd_rd_addr, ptr_inc;
    logic [VALUE_W-1:0] vd_rd_reg;
    logic [VALUE_W-1:0] vd_mem [MAX_WINDOW];

    logic [XW-1:0] t_x, k_x, j_x, jk_x, cnt_after_x;

    // (a - b) mod MAX_WINDOW for a in range and b at most MAX_WINDOW
    function automatic logic [AW-1:0] wrap_sub(input logic [AW-1:0] a, input logic [KW-1:0] b);
        logic [KW:0] diff;
        diff = (KW+1)'(a) - (KW+1)'(b);
        if (diff[KW])
            diff = diff + (KW+1)'(MAX_WINDOW);
        return diff[AW-1:0];
    endfunction

    always_comb
    begin
        ctl_c.active = !ovf_reg && (count_reg < CW'(MAX_ITEMS));
        ctl_c.last   = last;

        t_x  = XW'(count_reg);
        k_x  = XW'(k_reg);
        j_x  = t_x + XW'(1) - k_x;
        jk_x = j_x - k_x;

        ctl_c.sub_en     = t_x >= k_x;
        ctl_c.win_en     = ctl_c.active && (t_x + XW'(1) >= k_x);
        ctl_c.pair_en    = ctl_c.win_en && (j_x >= k_x);
        ctl_c.first_pair = j_x == k_x;

        cnt_after_x    = t_x + XW'(ctl_c.active);
        ctl_c.found_ok = ctl_c.active && (cnt_after_x >= (k_x << 1));

        ptr_inc    = (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
        vd_rd_addr = wrap_sub(ptr_reg, k_reg);
        sd_wr_c    = wrap_sub(ptr_inc, k_reg);
        sd_rd_addr = wrap_sub(sd_wr_c, k_reg);

        k_next     = k_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        ptr_next   = ptr_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
                k_next = KW'(1);
            else if (32'(cfg_wdata) > MAX_WINDOW)
                k_next = KW'(MAX_WINDOW);
            else
                k_next = KW'(cfg_wdata);
            count_next = '0;
            ovf_next   = 1'b0;
            ptr_next   = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                ptr_next   = '0;
            end
            else if (ctl_c.active)
            begin
                count_next = count_reg + CW'(1);
                ptr_next   = ptr_inc;
            end
            else
                ovf_next = 1'b1;
        end

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= KW'(1);
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else
        begin
            k_reg        <= k_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            ptr_reg      <= ptr_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
                ctl_reg <= ctl_c;
        end
    end

    // payload of the stage register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
            j_reg     <= j_x[IW-1:0];
            jk_reg    <= jk_x[IW-1:0];
            sd_wr_reg <= sd_wr_c;
        end
    end

    // value delay line, read-first: at full window length read and write share an entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (ctl_c.active)
                vd_mem[ptr_reg] <= value;
            vd_rd_reg <= vd_mem[vd_rd_addr];
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = ctl_reg;
    assign s1_value = value_reg;
    assign s1_j     = j_reg;
    assign s1_jk    = jk_reg;
    assign s1_sd_wr = sd_wr_reg;
    assign s1_vd_rd = vd_rd_reg;

endmodule

`default_nettype wire

[hdl/btdw_track.sv]
// Tracker stage: sliding window sum, window-sum delay memory, best window and best pair.
// Depends on btdw_pkg.
`default_nettype none

module btdw_track
    import btdw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int IW = $clog2(MAX_ITEMS),
    localparam int SW = VALUE_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               accept,
    input  logic [AW-1:0]      sd_rd_addr,
    input  logic               s1_go,
    input  s1_ctl_t            s1_ctl,
    input  logic [VALUE_W-1:0] s1_value,
    input  logic [IW-1:0]      s1_j,
    input  logic [IW-1:0]      s1_jk,
    input  logic [AW-1:0]      s1_sd_wr,
    input  logic [VALUE_W-1:0] s1_vd_rd,
    output result_t            result
);

    logic [SW-1:0] ws_reg, ws_next;
    logic [SW-1:0] bf_sum_reg, bf_sum_next;
    logic [IW-1:0] bf_idx_reg, bf_idx_next;
    logic [SW:0]   bp_reg, bp_next;
    logic [IW-1:0] pf_reg, pf_next;
    logic [IW-1:0] ps_reg, ps_next;
    logic [SW-1:0] sd_rd_reg;
    logic [SW-1:0] sd_mem [MAX_WINDOW];

    logic [SW-1:0] sub, s_new;
    logic [SW:0]   pair;
    logic          sd_we, fwd, clear;

    always_comb
    begin
        sub   = s1_ctl.sub_en ? SW'(s1_vd_rd) : '0;
        s_new = ws_reg - sub + SW'(s1_value);
        sd_we = s1_go && s1_ctl.win_en;
        fwd   = sd_we && (s1_sd_wr == sd_rd_addr);

        ws_next     = s1_ctl.active ? s_new : ws_reg;
        bf_sum_next = bf_sum_reg;
        bf_idx_next = bf_idx_reg;
        if (s1_ctl.pair_en && (sd_rd_reg > bf_sum_reg))
        begin
            bf_sum_next = sd_rd_reg;
            bf_idx_next = s1_jk;
        end

        pair    = {1'b0, s_new} + {1'b0, bf_sum_next};
        bp_next = bp_reg;
        pf_next = pf_reg;
        ps_next = ps_reg;
        if (s1_ctl.pair_en && (s1_ctl.first_pair || (pair > bp_reg)))
        begin
            bp_next = pair;
            pf_next = bf_idx_next;
            ps_next = s1_j;
        end

        result.found        = s1_ctl.found_ok;
        result.first_start  = s1_ctl.found_ok ? START_W'({1'b0, pf_next} + (IW+1)'(1)) : '0;
        result.second_start = s1_ctl.found_ok ? START_W'({1'b0, ps_next} + (IW+1)'(1)) : '0;

        clear = cfg_we || (s1_go && s1_ctl.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg     <= '0;
            bf_sum_reg <= '0;
            bf_idx_reg <= '0;
            bp_reg     <= '0;
            pf_reg     <= '0;
            ps_reg     <= '0;
        end
        else if (clear)
        begin
            ws_reg     <= '0;
            bf_sum_reg <= '0;
            bf_idx_reg <= '0;
            bp_reg     <= '0;
            pf_reg     <= '0;
            ps_reg     <= '0;
        end
        else if (s1_go)
        begin
            ws_reg     <= ws_next;
            bf_sum_reg <= bf_sum_next;
            bf_idx_reg <= bf_idx_next;
            bp_reg     <= bp_next;
            pf_reg     <= pf_next;
            ps_reg     <= ps_next;
        end
    end

    // window-sum delay line; a write landing on the entry read this edge is forwarded
    always_ff @(posedge clk)
    begin
        if (sd_we)
            sd_mem[s1_sd_wr] <= s_new;
        if (accept)
            sd_rd_reg <= fwd ? s_new : sd_mem[sd_rd_addr];
    end

endmodule

`default_nettype wire

[hdl/best_two_disjoint_windows.sv]
// Only last beats yield a result; each passes the stage 1 register, then the output register.
// Throughput: one beat per cycle while in_ready is high; the window and pair update bounds it.
// in_ready drops only while a finished result waits and the next last beat would overwrite it.
// Reset (rst_n, async low): window length 1, stream state and both pipeline stages empty.
// A window_length write also restarts the stream; delay memories need no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module best_two_disjoint_windows
    import btdw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LEN_W-1:0]   cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [START_W-1:0] first_start,
    output logic [START_W-1:0] second_start,
    output logic               found
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IW = $clog2(MAX_ITEMS);

    // stage 1 handoff between front and tracker
    logic               accept, s1_go, stall;
    logic               s1_valid;
    s1_ctl_t            s1_ctl;
    logic [VALUE_W-1:0] s1_value, s1_vd_rd;
    logic [IW-1:0]      s1_j, s1_jk;
    logic [AW-1:0]      s1_sd_wr, sd_rd_addr;
    result_t            result;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [START_W-1:0] first_start_reg, second_start_reg;
    logic               found_reg;

    // Stage 1 only ever blocks when it holds a last beat and the output
    // register is still full. Non-last beats always flow through, so input
    // keeps streaming while a result waits downstream.
    assign stall    = s1_valid && s1_ctl.last && out_valid_reg && !out_ready;
    assign s1_go    = s1_valid && !stall;
    assign in_ready = !stall;
    assign accept   = in_valid && in_ready;

    // Front: counter, overflow bound, delay addresses, value delay line.
    btdw_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .value      (value),
        .last       (last),
        .s1_go      (s1_go),
        .s1_valid   (s1_valid),
        .s1_ctl     (s1_ctl),
        .s1_value   (s1_value),
        .s1_j       (s1_j),
        .s1_jk      (s1_jk),
        .s1_sd_wr   (s1_sd_wr),
        .s1_vd_rd   (s1_vd_rd),
        .sd_rd_addr (sd_rd_addr)
    );

    // Tracker: sliding sum, best earlier window, best pair, result fields.
    btdw_track #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .accept     (accept),
        .sd_rd_addr (sd_rd_addr),
        .s1_go      (s1_go),
        .s1_ctl     (s1_ctl),
        .s1_value   (s1_value),
        .s1_j       (s1_j),
        .s1_jk      (s1_jk),
        .s1_sd_wr   (s1_sd_wr),
        .s1_vd_rd   (s1_vd_rd),
        .result     (result)
    );

    always_comb
    begin
        if (s1_go && s1_ctl.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result payload loads only when a last beat leaves stage 1
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_ctl.last)
        begin
            first_start_reg  <= result.first_start;
            second_start_reg <= result.second_start;
            found_reg        <= result.found;
        end
    end

    assign out_valid    = out_valid_reg;
    assign first_start  = first_start_reg;
    assign second_start = second_start_reg;
    assign found        = found_reg;

    // backpressure only ever comes from a pending result blocking a last beat
    `BTDW_ASSERT_IMPLIES(a_stall_cause, !in_ready,
        out_valid_reg && !out_ready && s1_valid && s1_ctl.last,
        "input stalled without a blocked result")

    // a last beat leaving stage 1 always shows up at the output
    `BTDW_ASSERT_NEXT(a_result_follows, s1_go && s1_ctl.last, out_valid_reg,
        "last beat produced no result")

    // a not-found result carries zero starts
    `BTDW_ASSERT_IMPLIES(a_nofind_zero, out_valid_reg && !found_reg,
        (first_start_reg == '0) && (second_start_reg == '0),
        "nonzero start with found low")

endmodule

`default_nettype wire

[bench/best_two_disjoint_windows_tb.sv]
// Self-checking bench for best_two_disjoint_windows: a directed table, a long receiver
// hold-off, then random streams under sender/receiver pacing. Needs btdw_pkg and the RTL.
module best_two_disjoint_windows_tb;
    import btdw_pkg::*;

    localparam int CLK_HALF        = 6;     // 12-unit period
    localparam int RESET_CYCLES    = 10;
    localparam int DRAIN_CYCLES    = 6;     // margin for the pipeline to drain
    localparam int STALL_LIMIT     = 2000;  // cycles with no handshake at all
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, well under the limit
    localparam int RANDOM_BEATS    = 950;
    localparam int PHASE_BEATS     = 130;
    localparam int REPORT_CAP      = 30;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    typedef enum logic [1:0] {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;
    typedef enum logic [1:0] {FILL_FULL, FILL_SMALL, FILL_SPARSE, FILL_HIGH} fill_t;
    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        row_kind_t          kind;
        logic [VALUE_W-1:0] data;   // value, or the new window length for ROW_CFG
        logic               lst;
        bit                 typed;
        result_t            want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [LEN_W-1:0]   cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic [START_W-1:0] first_start;
    logic [START_W-1:0] second_start;
    logic               found;

    best_two_disjoint_windows u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_start  (first_start),
        .second_start (second_start),
        .found        (found)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirror of the block's stream tracker
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]   len_reg;
    logic [VALUE_W-1:0] hist_vals [MAX_WINDOW_DEF];   // recent values, for the sliding sum
    logic [39:0]        win_hist  [MAX_WINDOW_DEF];   // completed window sums by start
    logic [39:0]        run_sum;
    logic [16:0]        seen_count;
    logic [39:0]        lead_sum;                     // best window ending before current one
    logic [15:0]        lead_idx;
    logic [40:0]        pair_sum;
    logic [15:0]        pair_lo;
    logic [15:0]        pair_hi;
    bit                 past_bound;

    result_t   pending_starts [$];   // expected results, oldest first
    stim_row_t plan [$];             // directed table

    pace_t pace;
    logic  hold_req;               // asks the receiver for one long hold-off
    int    beats_sent;
    int    results_checked;
    int    length_writes;
    int    mismatch_count;

    // length 0 behaves as 1, anything above the delay depth as the full depth
    function automatic int span_len();
        if (len_reg == '0)
            return 1;
        if (int'(len_reg) > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return int'(len_reg);
    endfunction

    // delay lines are left alone: every entry is rewritten before it is read
    function automatic void clear_stream();
        run_sum    = '0;
        seen_count = '0;
        lead_sum   = '0;
        lead_idx   = '0;
        pair_sum   = '0;
        pair_lo    = '0;
        pair_hi    = '0;
        past_bound = 1'b0;
    endfunction

    // Advance the tracker by one beat; returns 1 when the beat closes a stream.
    function automatic bit predict_pair(input logic [VALUE_W-1:0] v, input logic lst,
                                        output result_t r);
        int          k;
        int          t;
        int          j;
        logic [39:0] earlier;
        logic [40:0] pair;
        k = span_len();
        r = '0;
        if (!past_bound)
        begin
            if (int'(seen_count) >= MAX_ITEMS_DEF)
            begin
                // beyond the bound: ignore everything until last
                past_bound = 1'b1;
            end
            else
            begin
                t = int'(seen_count);
                if (t >= k)
                    run_sum = run_sum - 40'(hist_vals[(t - k) % MAX_WINDOW_DEF]);
                hist_vals[t % MAX_WINDOW_DEF] = v;
                run_sum    = run_sum + 40'(v);
                seen_count = 17'(t + 1);
                if (t + 1 >= k)
                begin
                    j = t + 1 - k;   // start of the window just completed
                    if (j >= k)
                    begin
                        earlier = win_hist[(j - k) % MAX_WINDOW_DEF];
                        // strict compares keep the earliest window on ties
                        if (earlier > lead_sum)
                        begin
                            lead_sum = earlier;
                            lead_idx = 16'(j - k);
                        end
                        pair = {1'b0, run_sum} + {1'b0, lead_sum};
                        if (j == k || pair > pair_sum)
                        begin
                            pair_sum = pair;
                            pair_lo  = lead_idx;
                            pair_hi  = 16'(j);
                        end
                    end
                    win_hist[j % MAX_WINDOW_DEF] = run_sum;
                end
            end
        end
        if (!lst)
            return 1'b0;
        if (!past_bound && int'(seen_count) >= 2 * k)
        begin
            r.first_start  = START_W'(pair_lo) + 1'b1;
            r.second_start = START_W'(pair_hi) + 1'b1;
            r.found        = 1'b1;
        end
        clear_stream();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // append one row to the directed table
    function automatic void add_row(input row_kind_t kind, input logic [VALUE_W-1:0] data,
                                    input logic lst, input bit typed, input result_t want);
        stim_row_t row;
        row.kind  = kind;
        row.data  = data;
        row.lst   = lst;
        row.typed = typed;
        row.want  = want;
        plan.insert(plan.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------
    function automatic logic [VALUE_W-1:0] pick_value(input fill_t fill);
        logic [VALUE_W-1:0] v;
        case (fill)
            FILL_SMALL:  v = VALUE_W'($urandom_range(7));            // lots of ties
            FILL_SPARSE: v = ($urandom_range(9) == 0) ? VALUE_W'($urandom) : '0;
            FILL_HIGH:   v = VALUE_MAX - VALUE_W'($urandom_range(15)); // widest sums
            default:     v = VALUE_W'($urandom);
        endcase
        return v;
    endfunction

    // Offer one beat and hold it until accepted. in_valid stays high afterwards so that
    // back-to-back beats never see a drop; a sender gap lowers it first.
    task automatic send_beat(input logic [VALUE_W-1:0] v, input logic lst,
                             input bit typed, input result_t want);
        result_t predicted;
        int      idle_pct;
        idle_pct = (pace == PACE_SENDER) ? 45 : (pace == PACE_BOTH) ? 30 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        if (predict_pair(v, lst, predicted))
            pending_starts.insert(pending_starts.size(), typed ? want : predicted);
    endtask

    task automatic send_stream(input int n, input fill_t fill, input bit closed);
        for (int i = 0; i < n; i++)
            send_beat(pick_value(fill), closed && (i == n - 1), 1'b0, '0);
    endtask

    // Length writes only with the block idle: all results home, pipeline drained.
    task automatic write_length(input logic [LEN_W-1:0] len);
        in_valid <= 1'b0;
        while (pending_starts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        len_reg = len;     // a write also restarts the stream
        clear_stream();
        length_writes++;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls per pacing phase, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (pace)
                    PACE_RECEIVER: out_ready <= ($urandom_range(99) >= 45);
                    PACE_BOTH:     out_ready <= ($urandom_range(99) >= 30);
                    default:       out_ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_starts.size() == 0)
            begin
                report_mismatch("result beat with nothing pending, found", found, 0);
            end
            else
            begin
                want = pending_starts.pop_front();
                if (first_start !== want.first_start)
                    report_mismatch("first_start", first_start, want.first_start);
                if (second_start !== want.second_start)
                    report_mismatch("second_start", second_start, want.second_start);
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no beat moves for too long
    // ------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending_starts.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int        random_beats;
        int        phase_beats;
        int        phase_no;
        int        roll;
        int        k;
        int        n;
        logic [LEN_W-1:0] len;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        value      = '0;
        last       = 1'b0;
        pace       = PACE_NONE;
        hold_req   = 1'b0;
        beats_sent = 0;
        results_checked = 0;
        length_writes   = 0;
        mismatch_count  = 0;
        len_reg = LEN_W'(1);   // reset length
        clear_stream();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Closing rows with a typed result are the ones that can be worked
        // out by hand; the rest go through the predictor.
        // reset length 1: two values, the first pair possible
        add_row(ROW_BEAT, 30'd5, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd7, 1'b1, 1'b1, {17'd1, 17'd2, 1'b1});
        // too short: one value closes the stream
        add_row(ROW_BEAT, VALUE_MAX, 1'b1, 1'b1, {17'd0, 17'd0, 1'b0});
        // equal windows: the earliest pair stays
        add_row(ROW_BEAT, 30'd3, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd3, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd3, 1'b1, 1'b1, {17'd1, 17'd2, 1'b1});
        // length 0 acts as 1; all-zero sums still report the first pair
        add_row(ROW_CFG, 30'd0, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd0, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd0, 1'b1, 1'b1, {17'd1, 17'd2, 1'b1});
        // length 3, six zeros: starts 1 and 4
        add_row(ROW_CFG, 30'd3, 1'b0, 1'b0, '0);
        for (int i = 0; i < 5; i++)
            add_row(ROW_BEAT, 30'd0, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd0, 1'b1, 1'b1, {17'd1, 17'd4, 1'b1});
        // open stream cut off by a length write, then a fresh stream at the extremes
        add_row(ROW_BEAT, VALUE_MAX, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd1, 1'b0, 1'b0, '0);
        add_row(ROW_CFG, 30'd2, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, VALUE_MAX, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, 30'd0, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, VALUE_MAX, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, VALUE_MAX, 1'b0, 1'b0, '0);
        add_row(ROW_BEAT, VALUE_MAX, 1'b1, 1'b0, '0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_length(plan[i].data[LEN_W-1:0]);
            else
                send_beat(plan[i].data, plan[i].lst, plan[i].typed, plan[i].want);
        end

        // Back-pressure: receiver holds off while short streams keep coming, so finished
        // results pile up and the block has to drop in_ready.
        write_length(LEN_W'(1));
        hold_req <= 1'b1;
        for (int i = 0; i < 40; i++)
            send_stream($urandom_range(1, 2), FILL_FULL, 1'b1);

        // Random phases, rotating through the pacing modes. Mostly well-formed streams long
        // enough for a pair, some too short, some left open and cut by the next length write.
        random_beats = 0;
        phase_no     = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                len = LEN_W'($urandom_range(1, 6));
            else if (roll < 85)
                len = LEN_W'($urandom_range(7, 40));
            else if (roll < 92)
                len = '0;
            else
                len = LEN_W'($urandom_range(MAX_WINDOW_DEF + 1, 2047));
            write_length(len);
            pace = pace_t'(phase_no % 4);
            k = span_len();
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                if (k >= MAX_WINDOW_DEF)
                    n = $urandom_range(1, 24);           // huge windows: short noise only
                else if ($urandom_range(99) < 80)
                    n = $urandom_range(2 * k, 5 * k + 8);
                else
                    n = (k == 1) ? 1 : $urandom_range(1, 2 * k - 1);
                send_stream(n, fill_t'($urandom_range(3)), 1'b1);
                phase_beats += n;
            end
            if ($urandom_range(99) < 40)
            begin
                n = $urandom_range(1, 5);
                send_stream(n, FILL_FULL, 1'b0);
                phase_beats += n;
            end
            random_beats += phase_beats;
            phase_no++;
        end

        // Wind down: all results home, then let the pipeline settle.
        in_valid <= 1'b0;
        while (pending_starts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d beats in, %0d results checked, %0d length writes, %0d random phases",
                 beats_sent, results_checked, length_writes, phase_no);
        $display("run: lengths 0 to 2047, short and open streams, pacing phases, long hold-off");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/btdw_pkg.sv
hdl/btdw_front.sv
hdl/btdw_track.sv
hdl/best_two_disjoint_windows.sv
bench/best_two_disjoint_windows_tb.sv
